FILE: hw/rtl/kst_pkg.sv
package kst_pkg;

    localparam int ID_W    = 16;
    localparam int VAR_W   = 16;
    localparam int WORD_W  = 32;
    localparam int ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } act_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

FILE: hw/rtl/kst_entry_ram.sv
module kst_entry_ram #(
    parameter int DEPTH   = 8,
    parameter int ENTRY_W = 96,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  kst_pkg::ram_ctl_t  ctl,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);
    import kst_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the scan is stalled
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/keyed_slot_table.sv
// Lookup and remove walk the slots through one registered-read comparator;
// a lookup ends early on a hit. Add scans the used marks, one slot a cycle;
// clear empties them. One item at a time.
// Reset clears the used marks and the handshake state; slot memory is not
// initialised, as the compare ignores a free slot's data by its used mark.
module keyed_slot_table #(
    parameter int SLOTS        = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kst_pkg::ACT_W-1:0]     action,
    input  logic signed [kst_pkg::ID_W-1:0] actor_id,
    input  logic [kst_pkg::VAR_W-1:0]     actor_variant,
    input  logic [kst_pkg::WORD_W-1:0]    payload_in,
    input  logic [kst_pkg::WORD_W-1:0]    extra_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [kst_pkg::WORD_W-1:0]    payload_out,
    output logic [kst_pkg::WORD_W-1:0]    extra_out
);
    import kst_pkg::*;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENTRY_W = ID_W + VAR_W + PAYLOAD_BITS + WORD_W;

    state_t                   state_reg, state_next;
    act_t                     act_reg;
    logic [ID_W-1:0]          id_reg;
    logic [VAR_W-1:0]         var_reg;
    logic [WORD_W-1:0]        payload_reg;
    logic [WORD_W-1:0]        extra_reg;

    logic [SLOTS-1:0]         used_reg, used_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;

    logic                     out_valid_reg;
    logic                     ok_reg;
    logic [WORD_W-1:0]        payload_out_reg;
    logic [WORD_W-1:0]        extra_out_reg;

    logic                     in_acc;
    logic                     out_free;
    logic [IDX_W-1:0]         scan_idx;
    logic                     scan_in_range;
    logic                     scan_last;
    logic                     cmp_hit;
    logic                     cmp_last;
    logic                     want_finish;
    logic                     finish;
    logic                     stall;
    logic                     advance;
    logic                     clr_slot;
    logic                     res_ok;
    logic [WORD_W-1:0]        res_payload;
    logic [WORD_W-1:0]        res_extra;

    ram_ctl_t                 ram_ctl;
    logic [ENTRY_W-1:0]       wr_entry;
    logic [ENTRY_W-1:0]       rd_entry;
    logic [ID_W-1:0]          rd_id;
    logic [VAR_W-1:0]         rd_var;
    logic [PAYLOAD_BITS-1:0]  rd_payload;
    logic [WORD_W-1:0]        rd_extra;
    logic [63:0]              pay_wide_in;
    logic [63:0]              pay_wide_out;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign scan_idx      = scan_cnt_reg[IDX_W-1:0];
    assign scan_in_range = (scan_cnt_reg < CNT_W'(SLOTS));
    assign scan_last     = (scan_cnt_reg == CNT_W'(SLOTS - 1));

    // entry layout: id, variant, payload, extra
    assign pay_wide_in = {32'd0, payload_reg};
    assign wr_entry    = {id_reg, var_reg, pay_wide_in[PAYLOAD_BITS-1:0], extra_reg};

    assign rd_id      = rd_entry[ENTRY_W-1 -: ID_W];
    assign rd_var     = rd_entry[ENTRY_W-ID_W-1 -: VAR_W];
    assign rd_payload = rd_entry[WORD_W +: PAYLOAD_BITS];
    assign rd_extra   = rd_entry[WORD_W-1:0];
    assign pay_wide_out = 64'(rd_payload);

    assign cmp_hit  = cmp_vld_reg && used_reg[cmp_idx_reg]
                      && (rd_id == id_reg) && (rd_var == var_reg);
    assign cmp_last = cmp_vld_reg && (cmp_idx_reg == IDX_W'(SLOTS - 1));

    kst_entry_ram #(
        .DEPTH   (SLOTS),
        .ENTRY_W (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (scan_idx),
        .wr_data (wr_entry),
        .rd_addr (scan_idx),
        .rd_data (rd_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        want_finish = 1'b0;
        advance     = 1'b0;
        clr_slot    = 1'b0;
        res_ok      = 1'b0;
        res_payload = '0;
        res_extra   = '0;
        case (state_reg)
            ST_SCAN:
            begin
                case (act_reg)
                    ACT_LOOKUP:
                    begin
                        advance = 1'b1;
                        if (cmp_hit)
                        begin
                            want_finish = 1'b1;
                            res_ok      = 1'b1;
                            res_payload = pay_wide_out[WORD_W-1:0];
                            res_extra   = rd_extra;
                        end
                        else if (cmp_last)
                        begin
                            want_finish = 1'b1;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (!used_reg[scan_idx])
                        begin
                            want_finish = 1'b1;
                            res_ok      = 1'b1;
                        end
                        else if (scan_last)
                        begin
                            want_finish = 1'b1;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        advance  = 1'b1;
                        clr_slot = cmp_hit;
                        if (cmp_last)
                        begin
                            want_finish = 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        want_finish = 1'b1;
                    end
                    default:
                    begin
                        want_finish = 1'b1;
                    end
                endcase
            end
            default:
            begin
                want_finish = 1'b0;
            end
        endcase
        stall  = want_finish && !out_free;
        finish = want_finish && out_free;

        ram_ctl.wr_en = finish && (act_reg == ACT_ADD) && res_ok;
        ram_ctl.rd_en = advance && !stall && scan_in_range
                        && ((act_reg == ACT_LOOKUP) || (act_reg == ACT_REMOVE));
    end

    // scan counter, compare stage and used marks
    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        used_next     = used_reg;
        if (in_acc)
        begin
            scan_cnt_next = '0;
            cmp_vld_next  = 1'b0;
        end
        else if (advance && !stall)
        begin
            if (scan_in_range)
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            cmp_vld_next = scan_in_range;
            cmp_idx_next = scan_idx;
        end
        if (clr_slot)
        begin
            used_next[cmp_idx_reg] = 1'b0;
        end
        if (ram_ctl.wr_en)
        begin
            used_next[scan_idx] = 1'b1;
        end
        if (finish && (act_reg == ACT_CLEAR))
        begin
            used_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        if (in_acc)
        begin
            act_reg     <= act_t'(action);
            id_reg      <= actor_id;
            var_reg     <= actor_variant;
            payload_reg <= payload_in;
            extra_reg   <= extra_in;
        end
        if (finish)
        begin
            ok_reg          <= res_ok;
            payload_out_reg <= res_payload;
            extra_out_reg   <= res_extra;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign payload_out = payload_out_reg;
    assign extra_out   = extra_out_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> ((payload_out == '0) && (extra_out == '0)))
        else $error("failed result carries data");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready straight after acceptance");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (act_reg == ACT_CLEAR)) |=> (used_reg == '0))
        else $error("used marks left after clear");

    a_add_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (act_reg == ACT_ADD) && !res_ok) |-> (&used_reg))
        else $error("add refused with a free slot");

endmodule
